[src/psl_pkg.sv]
package psl_pkg;

   // Command codes carried in the request tuser.
   localparam logic [1:0] CMD_APPEND = 2'd0;
   localparam logic [1:0] CMD_REMOVE = 2'd1;
   localparam logic [1:0] CMD_CLEAR  = 2'd2;
   localparam logic [1:0] CMD_LOCATE = 2'd3;

   // Operation codes of the shared add/subtract unit.
   localparam logic ALU_ADD = 1'b0;
   localparam logic ALU_SUB = 1'b1;

   // Fixed field widths of the streaming ports.
   localparam int IN_LEN_BITS   = 32;
   localparam int PROG_BITS     = 16;
   localparam int INDEX_BITS    = 6;
   localparam int COUNT_BITS    = 7;
   localparam int REQ_DATA_BITS = 80;
   localparam int RSP_DATA_BITS = 32;

   // The multiply and divide each take one step per fraction bit.
   localparam int FRAC_BITS = 16;
   localparam int STEP_BITS = 4;

   localparam int MAX_SEGMENTS_DEFAULT = 64;
   localparam int LENGTH_BITS_DEFAULT  = 32;

endpackage

[src/path_segment_locator_core.sv]
// Path segment locator. The block keeps a table of up to MAX_SEGMENTS segment
// lengths and takes one command per request transaction: append a length,
// remove the last entry, clear the table, or locate a point given as a Q0.16
// fraction of a total length. Every request yields exactly one response
// transaction carrying the segment index, the Q0.16 fraction within that
// segment, a found flag, the number of stored entries after the command and
// an overflow flag for an append that hit a full table. Append, remove, clear
// and a locate with a zero total length go straight to the response load.
// Any other locate runs on one shared add/subtract unit: a shift-and-add
// multiply, then a walk over the stored entries up to the one that holds
// the target, or past the last when none does, then, on a hit only, a
// restoring division, and then the response load. The block takes no new
// request until that load is done; the next request can be taken in the
// cycle after it. The response load waits as long as an earlier response
// is still held by the receiver. The walk rate is set by the table memory,
// which delivers one entry per cycle through its registered read port.
module path_segment_locator_core #(
   parameter int MAX_SEGMENTS = psl_pkg::MAX_SEGMENTS_DEFAULT,
   parameter int LENGTH_BITS  = psl_pkg::LENGTH_BITS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // tdata fields, lowest bit up: segment_length[31:0], progress[47:32],
   // total_length[79:48].
   input  logic [psl_pkg::REQ_DATA_BITS-1:0]  req_tdata,
   // tuser fields, lowest bit up: cmd[1:0].
   input  logic [1:0]                         req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // tdata fields, lowest bit up: segment_index[5:0], local_fraction[21:6],
   // found[22], segment_count[29:23], overflow[30], zero pad[31].
   output logic [psl_pkg::RSP_DATA_BITS-1:0]  rsp_tdata
);

   localparam int LB   = LENGTH_BITS;
   localparam int AW   = $clog2(MAX_SEGMENTS);
   localparam int CW   = $clog2(MAX_SEGMENTS + 1);
   localparam int FB   = psl_pkg::FRAC_BITS;
   localparam int SW   = psl_pkg::STEP_BITS;
   localparam int PW   = LB + FB;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_MUL  = 3'd1;
   localparam logic [2:0] ST_WALK = 3'd2;
   localparam logic [2:0] ST_DIV  = 3'd3;
   localparam logic [2:0] ST_FIN  = 3'd4;

   localparam logic [SW-1:0] LAST_STEP = SW'(FB - 1);

   logic [2:0]    state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [SW-1:0] step_ff, step_in;
   logic [LB-1:0] total_ff, total_in;
   logic [LB-1:0] rem_ff, rem_in;
   logic [LB-1:0] div_len_ff, div_len_in;
   // Holds progress, then the product; its low bits later shift the target
   // fraction out and the quotient in.
   logic [PW-1:0] prod_ff, prod_in;
   logic          found_ff, found_in;
   logic          ovf_ff, ovf_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [psl_pkg::RSP_DATA_BITS-1:0] rsp_data_ff, rsp_data_in;

   logic          req_accept;
   logic          rsp_free;
   logic [CW-1:0] idx_next;
   logic [LB-1:0] seg_len;
   logic [LB-1:0] req_total;

   logic          alu_op;
   logic [LB:0]   alu_a, alu_b, alu_y;

   logic          ram_we;
   logic [AW-1:0] ram_rd_addr;
   logic [LB-1:0] ram_rd_data;

   logic [LB:0]   div_r2;
   logic [15:0]   frac_out;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign seg_len   = LB'(req_tdata[psl_pkg::IN_LEN_BITS-1:0]);
   assign req_total = LB'(req_tdata[79:48]);
   assign idx_next  = idx_ff + 1'b1;
   assign div_r2    = {rem_ff, prod_ff[FB-1]};

   // Appends are written at acceptance; the count check keeps the address in range.
   assign ram_we = req_accept && (req_tuser == psl_pkg::CMD_APPEND) &&
                   (count_ff < CW'(MAX_SEGMENTS));

   // During the walk the next entry is fetched ahead, so that the registered
   // read data always belongs to the entry at idx_ff.
   assign ram_rd_addr = (state_ff == ST_WALK) ? idx_next[AW-1:0] : '0;

   psl_ram #(
      .WIDTH (LB),
      .DEPTH (MAX_SEGMENTS)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (seg_len),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Operand selection for the shared unit.
   always_comb begin
      alu_op = psl_pkg::ALU_ADD;
      alu_a  = '0;
      alu_b  = '0;
      case (state_ff)
         ST_MUL: begin
            alu_op = psl_pkg::ALU_ADD;
            alu_a  = {1'b0, prod_ff[PW-1:FB]};
            alu_b  = prod_ff[0] ? {1'b0, total_ff} : '0;
         end
         ST_WALK: begin
            alu_op = psl_pkg::ALU_SUB;
            alu_a  = {1'b0, rem_ff};
            alu_b  = {1'b0, ram_rd_data};
         end
         ST_DIV: begin
            alu_op = psl_pkg::ALU_SUB;
            alu_a  = div_r2;
            alu_b  = {1'b0, div_len_ff};
         end
         default: begin
            alu_op = psl_pkg::ALU_ADD;
         end
      endcase
   end

   psl_alu #(
      .WIDTH (LB + 1)
   ) u_alu (
      .op     (alu_op),
      .op_a   (alu_a),
      .op_b   (alu_b),
      .result (alu_y)
   );

   assign frac_out = found_ff ? prod_ff[FB-1:0] : '0;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      step_in      = step_ff;
      total_in     = total_ff;
      rem_in       = rem_ff;
      div_len_in   = div_len_ff;
      prod_in      = prod_ff;
      found_in     = found_ff;
      ovf_in       = ovf_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               found_in = 1'b0;
               ovf_in   = 1'b0;
               total_in = req_total;
               prod_in  = PW'(req_tdata[47:32]);
               step_in  = '0;
               idx_in   = '0;
               state_in = ST_FIN;
               case (req_tuser)
                  psl_pkg::CMD_APPEND: begin
                     if (count_ff < CW'(MAX_SEGMENTS)) begin
                        count_in = count_ff + 1'b1;
                     end else begin
                        ovf_in = 1'b1;
                     end
                  end
                  psl_pkg::CMD_REMOVE: begin
                     if (count_ff != '0) begin
                        count_in = count_ff - 1'b1;
                     end
                  end
                  psl_pkg::CMD_CLEAR: begin
                     count_in = '0;
                  end
                  psl_pkg::CMD_LOCATE: begin
                     if (req_total != '0) begin
                        state_in = ST_MUL;
                     end
                  end
                  default: begin
                     state_in = ST_FIN;
                  end
               endcase
            end
         end
         ST_MUL: begin
            // Shift-and-add, least significant progress bit first.
            prod_in = {alu_y, prod_ff[FB-1:1]};
            step_in = step_ff + 1'b1;
            if (step_ff == LAST_STEP) begin
               rem_in   = alu_y[LB:1];
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            // rem_ff holds the target minus the start of entry idx_ff.
            if (idx_ff == count_ff) begin
               state_in = ST_FIN;
            end else if (alu_y[LB]) begin
               // Target lies inside this entry; zero lengths never get here.
               found_in   = 1'b1;
               div_len_in = ram_rd_data;
               step_in    = '0;
               state_in   = ST_DIV;
            end else begin
               rem_in = alu_y[LB-1:0];
               idx_in = idx_next;
            end
         end
         ST_DIV: begin
            // Restoring division; the remainder always stays below the length.
            if (alu_y[LB]) begin
               rem_in  = div_r2[LB-1:0];
               prod_in = {prod_ff[PW-1:FB], prod_ff[FB-2:0], 1'b0};
            end else begin
               rem_in  = alu_y[LB-1:0];
               prod_in = {prod_ff[PW-1:FB], prod_ff[FB-2:0], 1'b1};
            end
            step_in = step_ff + 1'b1;
            if (step_ff == LAST_STEP) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {1'b0, ovf_ff,
                               psl_pkg::COUNT_BITS'(count_ff),
                               found_ff, frac_out,
                               found_ff ? psl_pkg::INDEX_BITS'(idx_ff) :
                                          psl_pkg::INDEX_BITS'(0)};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      step_ff     <= step_in;
      total_ff    <= total_in;
      rem_ff      <= rem_in;
      div_len_ff  <= div_len_in;
      prod_ff     <= prod_in;
      found_ff    <= found_in;
      ovf_ff      <= ovf_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

[src/psl_ram.sv]
module psl_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[src/psl_alu.sv]
module psl_alu #(
   parameter int WIDTH = 33
) (
   input  logic             op,
   input  logic [WIDTH-1:0] op_a,
   input  logic [WIDTH-1:0] op_b,
   output logic [WIDTH-1:0] result
);

   // Single adder shared by the multiply, walk and divide steps.
   always_comb begin
      case (op)
         psl_pkg::ALU_ADD: result = op_a + op_b;
         psl_pkg::ALU_SUB: result = op_a - op_b;
         default:          result = op_a + op_b;
      endcase
   end

endmodule

[test/tb_top.sv]
module tb_top;
   import psl_pkg::*;

   localparam int TABLE_DEPTH  = MAX_SEGMENTS_DEFAULT;
   localparam int PHASE_ITEMS  = 400;
   localparam int SETTLE_TICKS = 100;

   // Response fields; the first member sits in the top bits, so the
   // packed layout matches rsp_tdata[30:0] directly.
   typedef struct packed {
      logic                  ovf;
      logic [COUNT_BITS-1:0] count;
      logic                  found;
      logic [FRAC_BITS-1:0]  frac;
      logic [INDEX_BITS-1:0] seg_index;
   } loc_result_type;

   typedef struct {
      logic [1:0]             cmd;
      logic [IN_LEN_BITS-1:0] len;
      logic [PROG_BITS-1:0]   prog;
      logic [IN_LEN_BITS-1:0] total;
      bit                     typed;
      loc_result_type         want;
   } stim_row_type;

   logic                     clock      = 1'b0;
   logic                     reset      = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [REQ_DATA_BITS-1:0] req_tdata  = '0;
   logic [1:0]               req_tuser  = CMD_APPEND;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;

   // Shadow copy of the segment table.
   logic [IN_LEN_BITS-1:0] len_store [TABLE_DEPTH];
   int                     stored_entries = 0;

   loc_result_type pending_results [$];
   int             mismatch_count = 0;
   int             issued_items   = 0;
   int             tx_gap_pct     = 0;
   int             rx_stall_pct   = 0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   path_segment_locator_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // Adds one expected response at the tail of the queue.
   task automatic enqueue_expected(input loc_result_type res);
      pending_results.insert(pending_results.size(), res);
   endtask

   // Applies one command to the shadow table and works out its response.
   task automatic apply_command(input logic [1:0] cmd, input logic [IN_LEN_BITS-1:0] len,
                                input logic [PROG_BITS-1:0] prog,
                                input logic [IN_LEN_BITS-1:0] total,
                                output loc_result_type res);
      logic [63:0] scaled;
      logic [63:0] target;
      logic [63:0] start;
      logic [63:0] offset;
      bit          done;
      res = '0;
      case (cmd)
         CMD_APPEND: begin
            if (stored_entries < TABLE_DEPTH) begin
               len_store[stored_entries] = len;
               stored_entries++;
            end else begin
               res.ovf = 1'b1;
            end
         end
         CMD_REMOVE: begin
            if (stored_entries > 0) stored_entries--;
         end
         CMD_CLEAR: begin
            stored_entries = 0;
         end
         CMD_LOCATE: begin
            if (total != 0) begin
               scaled = 64'(prog) * 64'(total);
               target = scaled >> FRAC_BITS;
               start  = 0;
               done   = 1'b0;
               for (int i = 0; i < stored_entries && !done; i++) begin
                  if (start > target) begin
                     done = 1'b1;
                  end else if (len_store[i] != 0 && target - start < 64'(len_store[i])) begin
                     offset        = ((target - start) << FRAC_BITS) + 64'(scaled[15:0]);
                     res.frac      = FRAC_BITS'(offset / 64'(len_store[i]));
                     res.seg_index = INDEX_BITS'(i);
                     res.found     = 1'b1;
                     done          = 1'b1;
                  end else begin
                     start += 64'(len_store[i]);
                  end
               end
            end
         end
         default: begin
         end
      endcase
      res.count = COUNT_BITS'(stored_entries);
   endtask

   // Sum of the first n stored lengths, i.e. the start of segment n.
   function automatic logic [63:0] span_to(input int n);
      logic [63:0] acc;
      acc = 0;
      for (int i = 0; i < n; i++) acc += 64'(len_store[i]);
      return acc;
   endfunction

   function automatic logic [IN_LEN_BITS-1:0] pick_length();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return $urandom;
         2:       return $urandom_range(1, 3);
         default: return $urandom_range(1, 5000);
      endcase
   endfunction

   // Drives one request transaction. The ready is sampled at the falling edge, where
   // everything has settled, so the expectation is queued before the rising edge that
   // completes the transaction.
   task automatic send_command(input logic [1:0] cmd, input logic [IN_LEN_BITS-1:0] len,
                               input logic [PROG_BITS-1:0] prog,
                               input logic [IN_LEN_BITS-1:0] total,
                               input bit typed, input loc_result_type want);
      loc_result_type predicted;
      bit             taken;
      while ($urandom_range(0, 99) < tx_gap_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {total, prog, len};
      taken = 1'b0;
      while (!taken) begin
         @(negedge clock);
         if (req_tready) begin
            apply_command(cmd, len, prog, total, predicted);
            enqueue_expected(typed ? want : predicted);
            taken = 1'b1;
         end
         @(posedge clock);
      end
      issued_items++;
   endtask

   task automatic send_plain(input logic [1:0] cmd, input logic [IN_LEN_BITS-1:0] len);
      send_command(cmd, len, PROG_BITS'($urandom), $urandom, 1'b0, '0);
   endtask

   // Locates mostly aim inside the stored path: the total is the stored span, and some
   // progress values land exactly on a segment start.
   task automatic send_locate();
      logic [63:0]            span;
      logic [63:0]            bound;
      logic [63:0]            want_prog;
      logic [IN_LEN_BITS-1:0] total;
      logic [PROG_BITS-1:0]   prog;
      int                     pick;
      span  = span_to(stored_entries);
      total = (span != 0 && span <= 64'hFFFF_FFFF) ? span[31:0] : $urandom;
      pick  = $urandom_range(0, 19);
      if (pick == 0) total = '0;
      else if (pick < 3) total = $urandom;
      case ($urandom_range(0, 9))
         0:       prog = '1;
         1:       prog = '0;
         2, 3: begin
            prog = PROG_BITS'($urandom);
            if (total != 0 && stored_entries > 0) begin
               bound     = span_to($urandom_range(0, stored_entries - 1));
               want_prog = ((bound << FRAC_BITS) + 64'(total) - 1) / 64'(total);
               prog      = (want_prog > 64'hFFFF) ? '1 : PROG_BITS'(want_prog);
            end
         end
         default: prog = PROG_BITS'($urandom);
      endcase
      send_command(CMD_LOCATE, $urandom, prog, total, 1'b0, '0);
   endtask

   // Random part: mostly a table build followed by locates, plus full-table runs that
   // overflow, remove runs and fully random transactions.
   task automatic run_random(input int quota);
      int goal;
      int n;
      goal = issued_items + quota;
      // Every phase opens with a fill past the top of the table.
      n = 0;
      while (issued_items < goal) begin
         if (n == 0) n = 1;
         else n = $urandom_range(1, 10);
         case (n)
            1: begin
               send_plain(CMD_CLEAR, $urandom);
               while (stored_entries < TABLE_DEPTH) send_plain(CMD_APPEND, pick_length());
               repeat ($urandom_range(1, 3)) send_plain(CMD_APPEND, pick_length());
               repeat ($urandom_range(4, 10)) send_locate();
            end
            2: begin
               repeat ($urandom_range(1, 4))
                  send_plain(2'($urandom), $urandom);
            end
            3: begin
               repeat ($urandom_range(1, 5)) send_plain(CMD_REMOVE, $urandom);
               repeat ($urandom_range(1, 4)) send_locate();
            end
            default: begin
               if ($urandom_range(0, 3) != 0) send_plain(CMD_CLEAR, $urandom);
               n = ($urandom_range(0, 3) != 0) ? $urandom_range(0, 8) : $urandom_range(0, 64);
               repeat (n) send_plain(CMD_APPEND, pick_length());
               repeat ($urandom_range(2, 8)) send_locate();
            end
         endcase
      end
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic report_field(input string name, input longint want, input longint got);
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      mismatch_count++;
   endtask

   // Result stall pattern, redrawn every cycle.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
      end
   end

   // Response checker; values are stable at the falling edge and the transaction
   // completes at the rising edge that follows.
   always @(negedge clock) begin
      loc_result_type got;
      loc_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[30:0];
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected response, expected none actual %h", $time, rsp_tdata);
            mismatch_count++;
         end else begin
            want = pending_results.pop_front();
            if (got.seg_index != want.seg_index)
               report_field("segment_index", want.seg_index, got.seg_index);
            if (got.frac != want.frac) report_field("local_fraction", want.frac, got.frac);
            if (got.found != want.found) report_field("found", want.found, got.found);
            if (got.count != want.count) report_field("segment_count", want.count, got.count);
            if (got.ovf != want.ovf) report_field("overflow", want.ovf, got.ovf);
         end
      end
   end

   initial begin
      #30_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   // Directed rows: empty table, the widest length, zero total, zero-length segments
   // that are skipped, targets exactly on segment boundaries, targets past the end,
   // and removes on an empty table.
   stim_row_type directed_rows [22] = '{
      '{CMD_LOCATE, 32'h0, 16'hFFFF, 32'hFFFF_FFFF, 1'b1,
        '{seg_index:6'd0, frac:16'd0, found:1'b0, count:7'd0, ovf:1'b0}},
      '{CMD_REMOVE, 32'h0, 16'h0, 32'h0, 1'b1,
        '{seg_index:6'd0, frac:16'd0, found:1'b0, count:7'd0, ovf:1'b0}},
      '{CMD_APPEND, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b1,
        '{seg_index:6'd0, frac:16'd0, found:1'b0, count:7'd1, ovf:1'b0}},
      '{CMD_LOCATE, 32'h0, 16'h0, 32'hFFFF_FFFF, 1'b1,
        '{seg_index:6'd0, frac:16'd0, found:1'b1, count:7'd1, ovf:1'b0}},
      '{CMD_LOCATE, 32'h0, 16'hFFFF, 32'hFFFF_FFFF, 1'b0, '{default:'0}},
      '{CMD_LOCATE, 32'hFFFF_FFFF, 16'h8000, 32'h0, 1'b1,
        '{seg_index:6'd0, frac:16'd0, found:1'b0, count:7'd1, ovf:1'b0}},
      '{CMD_CLEAR, 32'h0, 16'h0, 32'h0, 1'b1,
        '{seg_index:6'd0, frac:16'd0, found:1'b0, count:7'd0, ovf:1'b0}},
      '{CMD_APPEND, 32'd0, 16'h0, 32'h0, 1'b1,
        '{seg_index:6'd0, frac:16'd0, found:1'b0, count:7'd1, ovf:1'b0}},
      '{CMD_APPEND, 32'd40, 16'h0, 32'h0, 1'b1,
        '{seg_index:6'd0, frac:16'd0, found:1'b0, count:7'd2, ovf:1'b0}},
      '{CMD_APPEND, 32'd0, 16'h0, 32'h0, 1'b1,
        '{seg_index:6'd0, frac:16'd0, found:1'b0, count:7'd3, ovf:1'b0}},
      '{CMD_APPEND, 32'd24, 16'h0, 32'h0, 1'b1,
        '{seg_index:6'd0, frac:16'd0, found:1'b0, count:7'd4, ovf:1'b0}},
      '{CMD_LOCATE, 32'h0, 16'h0, 32'd64, 1'b1,
        '{seg_index:6'd1, frac:16'd0, found:1'b1, count:7'd4, ovf:1'b0}},
      '{CMD_LOCATE, 32'h0, 16'h8000, 32'd64, 1'b0, '{default:'0}},
      '{CMD_LOCATE, 32'h0, 16'hA000, 32'd64, 1'b1,
        '{seg_index:6'd3, frac:16'd0, found:1'b1, count:7'd4, ovf:1'b0}},
      '{CMD_LOCATE, 32'h0, 16'hFFFF, 32'd64, 1'b0, '{default:'0}},
      '{CMD_LOCATE, 32'h0, 16'hFFFF, 32'hFFFF_FFFF, 1'b1,
        '{seg_index:6'd0, frac:16'd0, found:1'b0, count:7'd4, ovf:1'b0}},
      '{CMD_REMOVE, 32'h0, 16'h0, 32'h0, 1'b1,
        '{seg_index:6'd0, frac:16'd0, found:1'b0, count:7'd3, ovf:1'b0}},
      '{CMD_LOCATE, 32'h0, 16'hC000, 32'd64, 1'b1,
        '{seg_index:6'd0, frac:16'd0, found:1'b0, count:7'd3, ovf:1'b0}},
      '{CMD_APPEND, 32'hFFFF_FFFF, 16'h0, 32'h0, 1'b1,
        '{seg_index:6'd0, frac:16'd0, found:1'b0, count:7'd4, ovf:1'b0}},
      '{CMD_LOCATE, 32'h0, 16'h0001, 32'hFFFF_FFFF, 1'b0, '{default:'0}},
      '{CMD_CLEAR, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b1,
        '{seg_index:6'd0, frac:16'd0, found:1'b0, count:7'd0, ovf:1'b0}},
      '{CMD_REMOVE, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b1,
        '{seg_index:6'd0, frac:16'd0, found:1'b0, count:7'd0, ovf:1'b0}}
   };

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      tx_gap_pct   = 17;
      rx_stall_pct = 53;
      foreach (directed_rows[i])
         send_command(directed_rows[i].cmd, directed_rows[i].len, directed_rows[i].prog,
                      directed_rows[i].total, directed_rows[i].typed, directed_rows[i].want);
      run_random(PHASE_ITEMS);

      // Hold the requests back until every response of the phase is in.
      wait_drained();
      tx_gap_pct   = 53;
      rx_stall_pct = 17;
      run_random(PHASE_ITEMS);

      wait_drained();
      tx_gap_pct   = 0;
      rx_stall_pct = 0;
      run_random(PHASE_ITEMS);

      wait_drained();
      repeat (SETTLE_TICKS) @(posedge clock);
      if (mismatch_count == 0 && pending_results.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

[path_segment_locator_core.f]
src/psl_pkg.sv
src/psl_ram.sv
src/psl_alu.sv
src/path_segment_locator_core.sv
test/tb_top.sv
